// ----- design/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded positional deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned IO_W     = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned EXT_W    = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_INSERT     = 3'd5,
    CMD_ERASE      = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUMM
  } state_e;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;  // open a slot at the position and write the new word there
    logic era;  // close the slot at the position
  } cell_ctl_t;

endpackage

// ----- design/bdq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// One slot of the ordered row: holds a word, takes its left or right
// neighbor's word on a shift, and offers its word when selected.
// ----------------------------------------------------------------------------
module bdq_cell #(
  parameter int unsigned DataWidth = 32,
  parameter int unsigned PosWidth  = 5,
  parameter int unsigned Index     = 0
) (
  input  logic                  clk_i,
  input  bdq_pkg::cell_ctl_t    ctl_i,
  input  logic [PosWidth-1:0]   pos_i,
  input  logic [PosWidth-1:0]   sel_i,
  input  logic [DataWidth-1:0]  data_i,
  input  logic [DataWidth-1:0]  left_i,
  input  logic [DataWidth-1:0]  right_i,
  output logic [DataWidth-1:0]  word_o,
  output logic [DataWidth-1:0]  tap_o
);

  localparam logic [PosWidth-1:0] MyPos = PosWidth'(Index);

  logic [DataWidth-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctl_i.ins) begin
      if (MyPos > pos_i) begin
        word_d = left_i;
      end else if (MyPos == pos_i) begin
        word_d = data_i;
      end
    end else if (ctl_i.era && (MyPos >= pos_i)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign tap_o  = (MyPos == sel_i) ? word_q : '0;

endmodule

// ----- design/bounded_deque_positional_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_positional_core
// A command beat taken in idle runs an execute pass, then a summary pass that
// loads the result register once any earlier result is taken. No new command
// is taken until both passes over the shared selection tree of the row end.
// Reset clears the count and the control state; the row words are not reset.
// ----------------------------------------------------------------------------
module bounded_deque_positional_core #(
  parameter int unsigned DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bdq_pkg::CMD_W-1:0]      cmd_i,
  input  logic [bdq_pkg::POS_W-1:0]      position_i,
  input  logic [bdq_pkg::IO_W-1:0]       data_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bdq_pkg::STATUS_W-1:0]   status_o,
  output logic [bdq_pkg::IO_W-1:0]       read_data_o,
  output logic [bdq_pkg::IO_W-1:0]       front_data_o,
  output logic [bdq_pkg::IO_W-1:0]       back_data_o,
  output logic [bdq_pkg::COUNT_W-1:0]    item_count_o,
  output logic                           is_empty_o
);

  import bdq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned MW   = (CntW > POS_W) ? CntW : POS_W;
  localparam logic [MW-1:0] DepthM = MW'(DEPTH);

  // Control and command registers
  state_e                 state_q, state_d;
  cmd_e                   cmd_q;
  logic [POS_W-1:0]       pos_q;
  logic [DATA_WIDTH-1:0]  data_q;
  logic [CntW-1:0]        count_q, count_d;
  status_e                stat_q, stat_d;
  logic [DATA_WIDTH-1:0]  rd_q, rd_d;

  // Result register
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [IO_W-1:0]        out_rd_q, out_front_q, out_back_q;
  logic [COUNT_W-1:0]     out_count_q;
  logic                   out_empty_q;

  logic                   accept;
  logic                   exec_en;
  logic                   summ_load;

  logic [MW-1:0]          pos_w, cnt_w, cell_pos, sel;
  cell_ctl_t              ctl;
  logic [DATA_WIDTH-1:0]  word_w [DEPTH];
  logic [DATA_WIDTH-1:0]  tap_w  [DEPTH];
  logic [DATA_WIDTH-1:0]  sel_word;
  logic [EXT_W-1:0]       din_ext, sel_ext, front_ext;

  assign pos_w   = MW'(pos_q);
  assign cnt_w   = MW'(count_q);
  assign din_ext = EXT_W'(data_in_i);

  // ---------------- state machine ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_SUMM;
      ST_SUMM: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    exec_en    = 1'b0;
    summ_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: exec_en    = 1'b1;
      ST_SUMM: summ_load  = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // ---------------- command decode ----------------
  always_comb begin
    stat_d   = STAT_OK;
    count_d  = count_q;
    ctl      = '0;
    cell_pos = '0;
    rd_d     = '0;
    unique case (cmd_q)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (cnt_w >= DepthM) begin
          stat_d = STAT_FULL;
        end else begin
          ctl.ins  = 1'b1;
          cell_pos = (cmd_q == CMD_PUSH_FRONT) ? '0 : cnt_w;
          count_d  = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (count_q == '0) begin
          stat_d = STAT_EMPTY;
        end else begin
          ctl.era  = (cmd_q == CMD_POP_FRONT);
          count_d  = count_q - 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_w >= cnt_w) begin
          stat_d = STAT_RANGE;
        end else begin
          rd_d = sel_word;
        end
      end
      CMD_INSERT: begin
        if (pos_w > cnt_w) begin
          stat_d = STAT_RANGE;
        end else if (cnt_w >= DepthM) begin
          stat_d = STAT_FULL;
        end else begin
          ctl.ins  = 1'b1;
          cell_pos = pos_w;
          count_d  = count_q + 1'b1;
        end
      end
      CMD_ERASE: begin
        if (pos_w >= cnt_w) begin
          stat_d = STAT_RANGE;
        end else begin
          ctl.era  = 1'b1;
          cell_pos = pos_w;
          count_d  = count_q - 1'b1;
        end
      end
      CMD_CLEAR: count_d = '0;
      default:   count_d = count_q;
    endcase
    if (!exec_en) begin
      ctl = '0;
    end
  end

  // The execute pass selects the read position, the summary pass the back.
  assign sel = exec_en ? pos_w : (cnt_w - 1'b1);

  // ---------------- cell row ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = word_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = word_w[i+1];
    end
    bdq_cell #(
      .DataWidth (DATA_WIDTH),
      .PosWidth  (MW),
      .Index     (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (cell_pos),
      .sel_i   (sel),
      .data_i  (data_q),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (word_w[i]),
      .tap_o   (tap_w[i])
    );
  end

  // At most one cell matches the select, so an OR of the taps is the mux.
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_word = sel_word | tap_w[i];
    end
  end

  assign sel_ext   = EXT_W'(sel_word);
  assign front_ext = EXT_W'(word_w[0]);

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_CLEAR;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cmd_q <= cmd_e'(cmd_i);
      end
      if (exec_en) begin
        count_q <= count_d;
      end
      if (summ_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q  <= position_i;
      data_q <= din_ext[DATA_WIDTH-1:0];
    end
    if (exec_en) begin
      stat_q <= stat_d;
      rd_q   <= rd_d;
    end
    if (summ_load) begin
      out_status_q <= stat_q;
      out_rd_q     <= IO_W'(EXT_W'(rd_q));
      out_front_q  <= (count_q != '0) ? front_ext[IO_W-1:0] : '0;
      out_back_q   <= (count_q != '0) ? sel_ext[IO_W-1:0] : '0;
      out_count_q  <= COUNT_W'(count_q);
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_data_o  = out_rd_q;
  assign front_data_o = out_front_q;
  assign back_data_o  = out_back_q;
  assign item_count_o = out_count_q;
  assign is_empty_o   = out_empty_q;

  // ---------------- assertions ----------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_w <= DepthM)
    else $error("row count exceeds depth");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted command did not start execution");

  a_refused_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_en && (stat_d != STAT_OK)) |=> $stable(count_q))
    else $error("refused command changed the count");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    summ_load |=> (is_empty_o == (count_q == '0)))
    else $error("empty flag disagrees with count");

  a_empty_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_EMPTY)) |-> is_empty_o)
    else $error("empty status on a non-empty row");

endmodule
